[rtl/i2cm_pkg.sv]
// ============================================================================
// i2cm_pkg
// Shared sizes, the per-access control struct and the identification ROM
// image for the I2C master register block.
// ============================================================================
package i2cm_pkg;

  // Storage sizes and the widths that follow from them.
  localparam int RX_DEPTH  = 16;
  localparam int ROM_BYTES = 256;
  localparam int RX_AW     = $clog2(RX_DEPTH);
  localparam int RX_FW     = $clog2(RX_DEPTH + 1);
  localparam int PTR_W     = $clog2(ROM_BYTES);
  localparam int IMAGE_LEN = 136;

  // Stage-0 decisions of one accepted item, handed to the memory stage.
  typedef struct packed {
    logic              push;
    logic [RX_AW-1:0]  waddr;
    logic              pop_ok;
    logic [RX_AW-1:0]  raddr;
    logic [PTR_W-1:0]  rom_addr;
    logic              pop;
    logic [31:0]       value;
    logic              irq;
  } acc_t;

  typedef logic [ROM_BYTES-1:0][7:0]   rom_img_t;
  typedef logic [IMAGE_LEN-1:0][7:0]   img_t;
  typedef logic [255:0][PTR_W-1:0]     ptr_mod_t;

  localparam logic [7:0] VENDOR_TEXT [29] = '{
    8'h53, 8'h74, 8'h61, 8'h72, 8'h46, 8'h69, 8'h76, 8'h65, 8'h20, 8'h54,
    8'h65, 8'h63, 8'h68, 8'h6e, 8'h6f, 8'h6c, 8'h6f, 8'h67, 8'h79, 8'h20,
    8'h43, 8'h6f, 8'h2e, 8'h2c, 8'h20, 8'h4c, 8'h74, 8'h64, 8'h2e
  };

  localparam logic [7:0] PRODUCT_TEXT [31] = '{
    8'h56, 8'h46, 8'h37, 8'h31, 8'h31, 8'h30, 8'h41, 8'h31, 8'h2d, 8'h32,
    8'h32, 8'h32, 8'h38, 8'h2d, 8'h44, 8'h30, 8'h30, 8'h34, 8'h45, 8'h30,
    8'h30, 8'h30, 8'h2d, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30,
    8'h31
  };

  localparam logic [7:0] HW_ADDR_A [6] = '{8'h6c, 8'hcf, 8'h39, 8'h6c, 8'hde, 8'had};
  localparam logic [7:0] HW_ADDR_B [6] = '{8'h6c, 8'hcf, 8'h39, 8'h7c, 8'hae, 8'h5d};

  // Bit-reflected CRC-16 with polynomial 0x8005 over a slice of the image.
  // Evaluated at elaboration only.
  function automatic logic [15:0] image_crc(input img_t img, input int base, input int n);
    logic [15:0] r;
    logic [15:0] res;
    logic        top;
    int          i;
    int          b;
    r = '0;
    res = '0;
    for (i = 0; i < n; i++) begin
      for (b = 0; b < 8; b++) begin
        top = r[15];
        r = {r[14:0], img[base + i][b]};
        if (top) r = r ^ 16'h8005;
      end
    end
    for (b = 0; b < 16; b++) begin
      top = r[15];
      r = {r[14:0], 1'b0};
      if (top) r = r ^ 16'h8005;
    end
    for (b = 0; b < 16; b++) begin
      res[15 - b] = r[b];
    end
    return res;
  endfunction

  // Identification image: a header and two records, each closed by its CRC.
  function automatic rom_img_t rom_image();
    img_t        img;
    rom_img_t    rom;
    logic [15:0] crc;
    int          i;
    img = '0;
    img[0] = 8'h53;
    img[1] = 8'h46;
    img[2] = 8'h56;
    img[3] = 8'h46;
    img[4] = 8'h03;
    img[6] = 8'h02;
    img[8] = 8'h88;
    // First record at byte 12.
    img[12] = 8'h01;
    img[14] = 8'h01;
    img[16] = 8'h58;
    img[40] = 8'h20;
    img[41] = 8'h20;
    for (i = 0; i < 29; i++) img[42 + i] = VENDOR_TEXT[i];
    for (i = 0; i < 31; i++) img[74 + i] = PRODUCT_TEXT[i];
    crc = image_crc(img, 12, 94);
    img[106] = crc[7:0];
    img[107] = crc[15:8];
    // Second record at byte 108.
    img[108] = 8'h04;
    img[110] = 8'h02;
    img[112] = 8'h14;
    img[116] = 8'h03;
    img[118] = 8'hb1;
    img[119] = 8'h41;
    for (i = 0; i < 6; i++) img[120 + i] = HW_ADDR_A[i];
    for (i = 0; i < 6; i++) img[126 + i] = HW_ADDR_B[i];
    crc = image_crc(img, 108, 26);
    img[134] = crc[7:0];
    img[135] = crc[15:8];
    rom = '0;
    for (i = 0; i < ROM_BYTES && i < IMAGE_LEN; i++) rom[i] = img[i];
    return rom;
  endfunction

  // Table of a written pointer byte reduced modulo the ROM size.
  function automatic ptr_mod_t ptr_mod_table();
    ptr_mod_t t;
    int       i;
    for (i = 0; i < 256; i++) t[i] = PTR_W'(i % ROM_BYTES);
    return t;
  endfunction

endpackage

[rtl/i2cm_rom.sv]
// ============================================================================
// i2cm_rom
// Identification ROM with a registered read port.
// ============================================================================
module i2cm_rom (
  input  logic                       clk,
  input  logic                       re,
  input  logic [i2cm_pkg::PTR_W-1:0] addr,
  output logic [7:0]                 rd_data
);

  localparam i2cm_pkg::rom_img_t ROM_IMAGE = i2cm_pkg::rom_image();

  logic [7:0] rd_data_r;

  // Registered table lookup.
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= ROM_IMAGE[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/i2cm_rx_ram.sv]
// ============================================================================
// i2cm_rx_ram
// Receive FIFO storage: one write and one registered read port per cycle.
// A read of the entry written in the same cycle returns the new byte.
// ============================================================================
module i2cm_rx_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [i2cm_pkg::RX_AW-1:0] waddr,
  input  logic [7:0]                 wdata,
  input  logic                       re,
  input  logic [i2cm_pkg::RX_AW-1:0] raddr,
  output logic [7:0]                 rd_data
);

  logic [7:0] mem [i2cm_pkg::RX_DEPTH];
  logic [7:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with write-first forwarding.
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/i2cm_regs.sv]
// ============================================================================
// i2cm_regs
// Register file and access decode. Updates the map registers on the cycle an
// item is accepted and tells the memory stage what to read and write.
// ============================================================================
module i2cm_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                fire,
  input  logic                cmd,
  input  logic [7:0]          offset,
  input  logic [31:0]         wdata,
  output i2cm_pkg::acc_t      acc
);

  localparam int RX_AW = i2cm_pkg::RX_AW;
  localparam int RX_FW = i2cm_pkg::RX_FW;
  localparam int PTR_W = i2cm_pkg::PTR_W;

  localparam i2cm_pkg::ptr_mod_t PTR_MOD = i2cm_pkg::ptr_mod_table();

  localparam logic CMD_WRITE = 1'b1;

  localparam logic [9:0] ROM_DEV_ADDR = 10'h050;

  // Register offsets.
  localparam logic [7:0] OFS_CON       = 8'h00;
  localparam logic [7:0] OFS_TAR       = 8'h04;
  localparam logic [7:0] OFS_SAR       = 8'h08;
  localparam logic [7:0] OFS_DATA_CMD  = 8'h10;
  localparam logic [7:0] OFS_INTR_STAT = 8'h2C;
  localparam logic [7:0] OFS_INTR_MASK = 8'h30;
  localparam logic [7:0] OFS_RAW_INTR  = 8'h34;
  localparam logic [7:0] OFS_RX_TL     = 8'h38;
  localparam logic [7:0] OFS_TX_TL     = 8'h3C;
  localparam logic [7:0] OFS_CLR_INTR  = 8'h40;
  localparam logic [7:0] OFS_CLR_RX_UN = 8'h44;
  localparam logic [7:0] OFS_CLR_ABRT  = 8'h54;
  localparam logic [7:0] OFS_CLR_STOP  = 8'h60;
  localparam logic [7:0] OFS_ENABLE    = 8'h6C;
  localparam logic [7:0] OFS_STATUS    = 8'h70;
  localparam logic [7:0] OFS_RXFLR     = 8'h78;
  localparam logic [7:0] OFS_SDA_HOLD  = 8'h7C;
  localparam logic [7:0] OFS_NACK      = 8'h84;
  localparam logic [7:0] OFS_DMA_CR    = 8'h88;
  localparam logic [7:0] OFS_DMA_TDLR  = 8'h8C;
  localparam logic [7:0] OFS_DMA_RDLR  = 8'h90;
  localparam logic [7:0] OFS_SDA_SETUP = 8'h94;
  localparam logic [7:0] OFS_ACK_GEN   = 8'h98;
  localparam logic [7:0] OFS_EN_STATUS = 8'h9C;
  localparam logic [7:0] OFS_COMP_PARM = 8'hF4;
  localparam logic [7:0] OFS_COMP_VER  = 8'hF8;
  localparam logic [7:0] OFS_COMP_TYPE = 8'hFC;

  localparam logic [31:0] COMP_PARAM = 32'h0002_0F0F;
  localparam logic [31:0] COMP_VER   = 32'h3230_312A;
  localparam logic [31:0] COMP_TYPE  = 32'h4457_0140;

  // Raw interrupt bits.
  localparam logic [9:0] IRQ_RX_UNDER = 10'h001;
  localparam logic [9:0] IRQ_RX_FULL  = 10'h004;
  localparam logic [9:0] IRQ_TX_EMPTY = 10'h010;
  localparam logic [9:0] IRQ_TX_ABRT  = 10'h040;
  localparam logic [9:0] IRQ_STOP_DET = 10'h200;

  logic             rom_present_r;
  logic [6:0]       con_r, con_nxt;
  logic [9:0]       tar_r, tar_nxt;
  logic [9:0]       sar_r, sar_nxt;
  logic [10:0]      mask_r, mask_nxt;
  logic [9:0]       raw_r, raw_nxt;
  logic [7:0]       rx_tl_r, rx_tl_nxt;
  logic [7:0]       tx_tl_r, tx_tl_nxt;
  logic             enable_r, enable_nxt;
  logic [31:0]      sda_hold_r, sda_hold_nxt;
  logic [7:0]       sda_setup_r, sda_setup_nxt;
  logic             ack_gen_r, ack_gen_nxt;
  logic [1:0]       dma_cr_r, dma_cr_nxt;
  logic [7:0]       dma_tdlr_r, dma_tdlr_nxt;
  logic [7:0]       dma_rdlr_r, dma_rdlr_nxt;
  logic             nack_r, nack_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic [RX_FW-1:0] fill_r, fill_nxt;
  logic [RX_AW-1:0] head_r, head_nxt;

  logic             rom_here;
  logic [RX_AW:0]   tail_sum;
  logic [RX_AW-1:0] tail;
  logic [RX_AW-1:0] head_inc;
  logic [PTR_W-1:0] ptr_inc;
  logic             not_full;

  // FIFO and pointer address arithmetic.
  assign rom_here = rom_present_r && (tar_r == ROM_DEV_ADDR);
  assign tail_sum = (RX_AW+1)'(head_r) + (RX_AW+1)'(fill_r);
  assign tail     = (tail_sum >= (RX_AW+1)'(i2cm_pkg::RX_DEPTH))
                    ? RX_AW'(tail_sum - (RX_AW+1)'(i2cm_pkg::RX_DEPTH))
                    : RX_AW'(tail_sum);
  assign head_inc = (head_r == RX_AW'(i2cm_pkg::RX_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign ptr_inc  = (ptr_r == PTR_W'(i2cm_pkg::ROM_BYTES - 1)) ? '0 : ptr_r + 1'b1;
  assign not_full = (fill_r < RX_FW'(i2cm_pkg::RX_DEPTH));

  // Access decode and next register values.
  always_comb begin
    con_nxt       = con_r;
    tar_nxt       = tar_r;
    sar_nxt       = sar_r;
    mask_nxt      = mask_r;
    raw_nxt       = raw_r;
    rx_tl_nxt     = rx_tl_r;
    tx_tl_nxt     = tx_tl_r;
    enable_nxt    = enable_r;
    sda_hold_nxt  = sda_hold_r;
    sda_setup_nxt = sda_setup_r;
    ack_gen_nxt   = ack_gen_r;
    dma_cr_nxt    = dma_cr_r;
    dma_tdlr_nxt  = dma_tdlr_r;
    dma_rdlr_nxt  = dma_rdlr_r;
    nack_nxt      = nack_r;
    ptr_nxt       = ptr_r;
    fill_nxt      = fill_r;
    head_nxt      = head_r;

    acc          = '0;
    acc.waddr    = tail;
    acc.raddr    = head_r;
    acc.rom_addr = ptr_r;

    if (fire) begin
      if (cmd == CMD_WRITE) begin
        case (offset)
          OFS_CON:       con_nxt       = wdata[6:0];
          OFS_TAR:       tar_nxt       = wdata[9:0];
          OFS_SAR:       sar_nxt       = wdata[9:0];
          OFS_DATA_CMD: begin
            if (!rom_here) begin
              raw_nxt = raw_r | IRQ_TX_ABRT;
            end else if (wdata[8]) begin
              // Read the next ROM byte; a full FIFO drops it.
              if (not_full) begin
                acc.push = 1'b1;
                fill_nxt = fill_r + 1'b1;
              end
              ptr_nxt = ptr_inc;
              raw_nxt = raw_r | (not_full ? IRQ_RX_FULL : '0) | IRQ_STOP_DET | IRQ_TX_EMPTY;
            end else begin
              ptr_nxt = PTR_MOD[wdata[7:0]];
              raw_nxt = raw_r | IRQ_TX_EMPTY;
            end
          end
          OFS_INTR_MASK: mask_nxt      = wdata[10:0];
          OFS_RX_TL:     rx_tl_nxt     = wdata[7:0];
          OFS_TX_TL:     tx_tl_nxt     = wdata[7:0];
          OFS_ENABLE:    enable_nxt    = wdata[0];
          OFS_SDA_HOLD:  sda_hold_nxt  = wdata;
          OFS_NACK:      nack_nxt      = wdata[0];
          OFS_DMA_CR:    dma_cr_nxt    = wdata[1:0];
          OFS_DMA_TDLR:  dma_tdlr_nxt  = wdata[7:0];
          OFS_DMA_RDLR:  dma_rdlr_nxt  = wdata[7:0];
          OFS_SDA_SETUP: sda_setup_nxt = wdata[7:0];
          OFS_ACK_GEN:   ack_gen_nxt   = wdata[0];
          default: ;
        endcase
      end else begin
        case (offset)
          OFS_CON:       acc.value = 32'(con_r);
          OFS_TAR:       acc.value = 32'(tar_r);
          OFS_SAR:       acc.value = 32'(sar_r);
          OFS_DATA_CMD: begin
            acc.pop = 1'b1;
            if (fill_r == '0) begin
              // Underflow: return all ones in the low byte.
              acc.value = 32'h0000_00FF;
              raw_nxt   = raw_r | IRQ_RX_UNDER;
            end else begin
              acc.pop_ok = 1'b1;
              fill_nxt   = fill_r - 1'b1;
              head_nxt   = head_inc;
              if (fill_r == RX_FW'(1)) begin
                head_nxt = '0;
                raw_nxt  = raw_r & ~IRQ_RX_FULL;
              end
            end
          end
          OFS_INTR_STAT: acc.value = 32'(raw_r & mask_r[9:0]);
          OFS_INTR_MASK: acc.value = 32'(mask_r);
          OFS_RAW_INTR:  acc.value = 32'(raw_r);
          OFS_RX_TL:     acc.value = 32'(rx_tl_r);
          OFS_TX_TL:     acc.value = 32'(tx_tl_r);
          OFS_CLR_INTR:  raw_nxt   = '0;
          OFS_CLR_RX_UN: raw_nxt   = raw_r & ~IRQ_RX_UNDER;
          OFS_CLR_ABRT:  raw_nxt   = raw_r & ~IRQ_TX_ABRT;
          OFS_CLR_STOP:  raw_nxt   = raw_r & ~IRQ_STOP_DET;
          OFS_ENABLE:    acc.value = 32'(enable_r);
          OFS_STATUS: begin
            if (enable_r) begin
              acc.value = {28'b0, (fill_r != '0), 3'b110};
            end
          end
          OFS_RXFLR:     acc.value = 32'(fill_r);
          OFS_SDA_HOLD:  acc.value = sda_hold_r;
          OFS_NACK:      acc.value = 32'(nack_r);
          OFS_DMA_CR:    acc.value = 32'(dma_cr_r);
          OFS_DMA_TDLR:  acc.value = 32'(dma_tdlr_r);
          OFS_DMA_RDLR:  acc.value = 32'(dma_rdlr_r);
          OFS_SDA_SETUP: acc.value = 32'(sda_setup_r);
          OFS_ACK_GEN:   acc.value = 32'(ack_gen_r);
          OFS_EN_STATUS: acc.value = 32'(enable_r);
          OFS_COMP_PARM: acc.value = COMP_PARAM;
          OFS_COMP_VER:  acc.value = COMP_VER;
          OFS_COMP_TYPE: acc.value = COMP_TYPE;
          default: ;
        endcase
      end
    end

    // Interrupt line as it stands after the access.
    acc.irq = |(raw_nxt & mask_nxt[9:0]);
  end

  // Register update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_present_r <= 1'b0;
      con_r         <= 7'h63;
      tar_r         <= '0;
      sar_r         <= '0;
      mask_r        <= '0;
      raw_r         <= '0;
      rx_tl_r       <= '0;
      tx_tl_r       <= '0;
      enable_r      <= 1'b0;
      sda_hold_r    <= '0;
      sda_setup_r   <= '0;
      ack_gen_r     <= 1'b0;
      dma_cr_r      <= '0;
      dma_tdlr_r    <= '0;
      dma_rdlr_r    <= '0;
      nack_r        <= 1'b0;
      ptr_r         <= '0;
      fill_r        <= '0;
      head_r        <= '0;
    end else begin
      if (cfg_we) begin
        rom_present_r <= cfg_wdata;
      end
      con_r       <= con_nxt;
      tar_r       <= tar_nxt;
      sar_r       <= sar_nxt;
      mask_r      <= mask_nxt;
      raw_r       <= raw_nxt;
      rx_tl_r     <= rx_tl_nxt;
      tx_tl_r     <= tx_tl_nxt;
      enable_r    <= enable_nxt;
      sda_hold_r  <= sda_hold_nxt;
      sda_setup_r <= sda_setup_nxt;
      ack_gen_r   <= ack_gen_nxt;
      dma_cr_r    <= dma_cr_nxt;
      dma_tdlr_r  <= dma_tdlr_nxt;
      dma_rdlr_r  <= dma_rdlr_nxt;
      nack_r      <= nack_nxt;
      ptr_r       <= ptr_nxt;
      fill_r      <= fill_nxt;
      head_r      <= head_nxt;
    end
  end

endmodule

[rtl/i2c_master_regs_with_eeprom.sv]
// ============================================================================
// i2c_master_regs_with_eeprom
// Register model of an I2C master with an identification ROM on the bus.
// ============================================================================
// Usage:
//   Each input item is one 32-bit register access: in_tuser carries the
//   command (0 read, 1 write), in_tdata the offset and the write data.
//   Every item yields exactly one result item with the read data (zero for
//   writes) and the interrupt line as it stands after the access.
//   cfg_we/cfg_wdata set the "ROM answers at 0x50" flag while idle.
// Timing:
//   One item per cycle sustained while out_tready is high. Stage 0 updates
//   the registers and issues the ROM and receive-FIFO reads; stage 1 takes
//   the registered memory data and writes a fetched ROM byte into the FIFO
//   RAM; the result then sits in the output register. A result is presented
//   once its item has passed the stage-1 register and the output register.
//   A pop that follows a push to the same entry is served by write-first
//   forwarding in the FIFO RAM.
// Reset and stall:
//   Synchronous reset clears the register map, FIFO level and valid bits; the
//   ROM is a constant table and needs no initialization. With a result waiting
//   on low out_tready, an empty stage 1 takes a last item; then in_tready is low.
// ============================================================================
module i2c_master_regs_with_eeprom (
  input  logic        clk,
  input  logic        rst_n,
  // Input items.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] reg_offset, [39:8] write_value
  input  logic        in_tuser,   // [0] command
  // Result items.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] read_value, [32] irq_level, [39:33] zero
  // Configuration.
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  i2cm_pkg::acc_t acc;
  i2cm_pkg::acc_t s1_r;
  logic           s1_valid_r;
  logic           s1_go;
  logic           in_fire;
  logic [7:0]     rom_rd;
  logic [7:0]     ram_rd;
  logic           out_valid_r;
  logic [31:0]    out_data_r, out_data_nxt;
  logic           out_irq_r;

  assign s1_go     = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_go;
  assign in_fire   = in_tvalid && in_tready;

  // Register file and decode.
  i2cm_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (in_fire),
    .cmd       (in_tuser),
    .offset    (in_tdata[7:0]),
    .wdata     (in_tdata[39:8]),
    .acc       (acc)
  );

  // Identification ROM.
  i2cm_rom u_rom (
    .clk     (clk),
    .re      (in_fire && acc.push),
    .addr    (acc.rom_addr),
    .rd_data (rom_rd)
  );

  // Receive FIFO storage.
  i2cm_rx_ram u_rx_ram (
    .clk     (clk),
    .we      (s1_valid_r && s1_r.push),
    .waddr   (s1_r.waddr),
    .wdata   (rom_rd),
    .re      (in_fire && acc.pop_ok),
    .raddr   (acc.raddr),
    .rd_data (ram_rd)
  );

  // Result value: FIFO byte for a successful pop, else the decoded value.
  assign out_data_nxt = s1_r.pop_ok ? 32'(ram_rd) : s1_r.value;

  // Stage 1 and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= acc;
    end
    if (s1_go && s1_valid_r) begin
      out_data_r <= out_data_nxt;
      out_irq_r  <= s1_r.irq;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_irq_r, out_data_r};

  // A single access never both pushes and pops the receive FIFO.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !(acc.push && acc.pop))
    else $error("FIFO push and pop decoded for one access");

  // An accepted push reaches stage 1 and drives the FIFO write next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && acc.push) |=> (s1_valid_r && s1_r.push))
    else $error("Accepted push did not reach the FIFO write stage");

  // An underflowing pop carries the all-ones byte and no memory data.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_r.pop && !s1_r.pop_ok) |-> (s1_r.value == 32'h0000_00FF))
    else $error("Underflow pop does not return the fill byte");

  // A successful pop only happens from a read access, never with a push.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_r.pop_ok) |-> (s1_r.pop && !s1_r.push))
    else $error("FIFO read data selected for a non-pop access");

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master register block testbench
// Drives one register access per item and checks every reply (read data and
// interrupt line) against a cycle-free model of the register map, the receive
// FIFO and the identification ROM. Outside the no-idle phase both stream sides
// idle at random; the receiver holds off for long stretches, and the ROM-present
// flag is changed between phases of traffic.
// ----------------------------------------------------------------------------
module tb_top;

  // Register map offsets.
  localparam logic [7:0] OFF_CON           = 8'h00;
  localparam logic [7:0] OFF_TAR           = 8'h04;
  localparam logic [7:0] OFF_SAR           = 8'h08;
  localparam logic [7:0] OFF_DATA_CMD      = 8'h10;
  localparam logic [7:0] OFF_SS_HCNT       = 8'h14;
  localparam logic [7:0] OFF_SS_LCNT       = 8'h18;
  localparam logic [7:0] OFF_FS_HCNT       = 8'h1C;
  localparam logic [7:0] OFF_FS_LCNT       = 8'h20;
  localparam logic [7:0] OFF_INTR_STAT     = 8'h2C;
  localparam logic [7:0] OFF_INTR_MASK     = 8'h30;
  localparam logic [7:0] OFF_RAW_INTR      = 8'h34;
  localparam logic [7:0] OFF_RX_TL         = 8'h38;
  localparam logic [7:0] OFF_TX_TL         = 8'h3C;
  localparam logic [7:0] OFF_CLR_INTR      = 8'h40;
  localparam logic [7:0] OFF_CLR_RX_UNDER  = 8'h44;
  localparam logic [7:0] OFF_CLR_TX_ABRT   = 8'h54;
  localparam logic [7:0] OFF_CLR_STOP_DET  = 8'h60;
  localparam logic [7:0] OFF_ENABLE        = 8'h6C;
  localparam logic [7:0] OFF_STATUS        = 8'h70;
  localparam logic [7:0] OFF_RXFLR         = 8'h78;
  localparam logic [7:0] OFF_SDA_HOLD      = 8'h7C;
  localparam logic [7:0] OFF_DATA_NACK     = 8'h84;
  localparam logic [7:0] OFF_DMA_CR        = 8'h88;
  localparam logic [7:0] OFF_DMA_TDLR      = 8'h8C;
  localparam logic [7:0] OFF_DMA_RDLR      = 8'h90;
  localparam logic [7:0] OFF_SDA_SETUP     = 8'h94;
  localparam logic [7:0] OFF_ACK_GC        = 8'h98;
  localparam logic [7:0] OFF_ENABLE_STATUS = 8'h9C;
  localparam logic [7:0] OFF_COMP_PARAM    = 8'hF4;
  localparam logic [7:0] OFF_COMP_VER      = 8'hF8;
  localparam logic [7:0] OFF_COMP_TYPE     = 8'hFC;

  localparam logic [7:0] REG_MAP [31] = '{
    OFF_CON, OFF_TAR, OFF_SAR, OFF_DATA_CMD, OFF_SS_HCNT, OFF_SS_LCNT,
    OFF_FS_HCNT, OFF_FS_LCNT, OFF_INTR_STAT, OFF_INTR_MASK, OFF_RAW_INTR,
    OFF_RX_TL, OFF_TX_TL, OFF_CLR_INTR, OFF_CLR_RX_UNDER, OFF_CLR_TX_ABRT,
    OFF_CLR_STOP_DET, OFF_ENABLE, OFF_STATUS, OFF_RXFLR, OFF_SDA_HOLD,
    OFF_DATA_NACK, OFF_DMA_CR, OFF_DMA_TDLR, OFF_DMA_RDLR, OFF_SDA_SETUP,
    OFF_ACK_GC, OFF_ENABLE_STATUS, OFF_COMP_PARAM, OFF_COMP_VER, OFF_COMP_TYPE
  };

  // Fixed identification values.
  localparam logic [31:0] COMP_PARAM_VAL = 32'h0002_0F0F;
  localparam logic [31:0] COMP_VER_VAL   = 32'h3230_312A;
  localparam logic [31:0] COMP_TYPE_VAL  = 32'h4457_0140;
  localparam logic [9:0]  ROM_DEV_ADDR   = 10'h050;
  localparam logic [31:0] DATA_CMD_READ  = 32'h0000_0100;

  // Raw interrupt bits.
  localparam logic [9:0] IRQ_RX_UNDER = 10'h001;
  localparam logic [9:0] IRQ_RX_FULL  = 10'h004;
  localparam logic [9:0] IRQ_TX_EMPTY = 10'h010;
  localparam logic [9:0] IRQ_TX_ABRT  = 10'h040;
  localparam logic [9:0] IRQ_STOP_DET = 10'h200;

  localparam int RX_SLOTS    = 16;
  localparam int HOLD_CYCLES = 200;
  localparam int QUIET_LIMIT = 2000;

  // Identification strings and hardware addresses, first byte highest.
  localparam logic [8*29-1:0] MAKER_BYTES =
    232'h53_74_61_72_46_69_76_65_20_54_65_63_68_6e_6f_6c_6f_67_79_20_43_6f_2e_2c_20_4c_74_64_2e;
  localparam logic [8*31-1:0] PART_BYTES =
    248'h56_46_37_31_31_30_41_31_2d_32_32_32_38_2d_44_30_30_34_45_30_30_30_2d_30_30_30_30_30_30_30_31;
  localparam logic [47:0] MAC_A = 48'h6c_cf_39_6c_de_ad;
  localparam logic [47:0] MAC_B = 48'h6c_cf_39_7c_ae_5d;

  typedef enum logic {ACC_READ = 1'b0, ACC_WRITE = 1'b1} acc_kind_e;

  typedef struct packed {
    acc_kind_e   kind;
    logic [7:0]  offset;
    logic [31:0] wdata;
  } reg_access_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        irq;
  } reg_reply_t;

  // DUT connections.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // [7:0] reg_offset, [39:8] write_value
  logic        in_tuser = 1'b0; // [0] command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // [31:0] read_value, [32] irq_level, [39:33] zero
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;

  i2c_master_regs_with_eeprom dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // Register file model.
  logic        m_rom_on;
  logic [6:0]  m_ctl;
  logic [9:0]  m_tar;
  logic [9:0]  m_sar;
  logic [10:0] m_mask;
  logic [9:0]  m_raw;
  logic [7:0]  m_rx_tl;
  logic [7:0]  m_tx_tl;
  logic        m_en;
  logic [31:0] m_sda_hold;
  logic [7:0]  m_sda_setup;
  logic        m_gc_ack;
  logic [1:0]  m_dma_cr;
  logic [7:0]  m_dma_tdlr;
  logic [7:0]  m_dma_rdlr;
  logic        m_nack;
  logic [7:0]  m_rom_ptr;
  logic [7:0]  id_rom [256];
  logic [7:0]  m_rxq [RX_SLOTS];
  logic [4:0]  m_rx_level;
  logic [3:0]  m_rx_head;

  // Test control.
  reg_access_t pending_accesses[$];
  reg_reply_t  expected_replies[$];
  int          n_queued = 0;
  int          n_taken = 0;
  int          fail_count = 0;
  int          src_idle_pct = 30;
  int          snk_idle_pct = 30;
  int          hold_trig = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  logic        in_fire = 1'b0;

  // Clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bit-reflected CRC-16, polynomial 0x8005, over a slice of the ROM image.
  function automatic logic [15:0] id_crc(input int first, input int count);
    logic [15:0] lfsr;
    logic [15:0] refl;
    logic        msb;
    int          i;
    int          b;
    lfsr = '0;
    for (i = 0; i < count; i++) begin
      for (b = 0; b < 8; b++) begin
        msb = lfsr[15];
        lfsr = {lfsr[14:0], id_rom[first + i][b]};
        if (msb) lfsr = lfsr ^ 16'h8005;
      end
    end
    for (b = 0; b < 16; b++) begin
      msb = lfsr[15];
      lfsr = {lfsr[14:0], 1'b0};
      if (msb) lfsr = lfsr ^ 16'h8005;
    end
    for (b = 0; b < 16; b++) refl[15 - b] = lfsr[b];
    return refl;
  endfunction

  // Identification image: header, a text record and an address record.
  initial begin : id_image
    logic [15:0] crc;
    int          k;
    for (k = 0; k < 256; k++) id_rom[k] = 8'h00;
    id_rom[0] = 8'h53;
    id_rom[1] = 8'h46;
    id_rom[2] = 8'h56;
    id_rom[3] = 8'h46;
    id_rom[4] = 8'h03;
    id_rom[6] = 8'h02;
    id_rom[8] = 8'h88;
    id_rom[12] = 8'h01;
    id_rom[14] = 8'h01;
    id_rom[16] = 8'h58;
    id_rom[40] = 8'h20;
    id_rom[41] = 8'h20;
    for (k = 0; k < 29; k++) id_rom[42 + k] = MAKER_BYTES[8*(28 - k) +: 8];
    for (k = 0; k < 31; k++) id_rom[74 + k] = PART_BYTES[8*(30 - k) +: 8];
    id_rom[108] = 8'h04;
    id_rom[110] = 8'h02;
    id_rom[112] = 8'h14;
    id_rom[116] = 8'h03;
    id_rom[118] = 8'hb1;
    id_rom[119] = 8'h41;
    for (k = 0; k < 6; k++) begin
      id_rom[120 + k] = MAC_A[8*(5 - k) +: 8];
      id_rom[126 + k] = MAC_B[8*(5 - k) +: 8];
    end
    crc = id_crc(12, 94);
    id_rom[106] = crc[7:0];
    id_rom[107] = crc[15:8];
    crc = id_crc(108, 26);
    id_rom[134] = crc[7:0];
    id_rom[135] = crc[15:8];
  end

  // Applies one access to the model and returns the reply it should produce.
  function automatic reg_reply_t predict_reply(input reg_access_t acc);
    reg_reply_t rep;
    logic       rom_here;
    rep.rdata = '0;
    if (acc.kind == ACC_WRITE) begin
      rom_here = m_rom_on && (m_tar == ROM_DEV_ADDR);
      case (acc.offset)
        OFF_CON:       m_ctl = acc.wdata[6:0];
        OFF_TAR:       m_tar = acc.wdata[9:0];
        OFF_SAR:       m_sar = acc.wdata[9:0];
        OFF_DATA_CMD: begin
          if (!rom_here) begin
            m_raw = m_raw | IRQ_TX_ABRT;
          end else if (acc.wdata[8]) begin
            // Fetch the next ROM byte; it is dropped when the FIFO is full.
            if (m_rx_level < RX_SLOTS) begin
              m_rxq[4'(m_rx_head + m_rx_level[3:0])] = id_rom[m_rom_ptr];
              m_rx_level = m_rx_level + 5'd1;
              m_raw = m_raw | IRQ_RX_FULL;
            end
            m_rom_ptr = m_rom_ptr + 8'd1;
            m_raw = m_raw | IRQ_STOP_DET | IRQ_TX_EMPTY;
          end else begin
            m_rom_ptr = acc.wdata[7:0];
            m_raw = m_raw | IRQ_TX_EMPTY;
          end
        end
        OFF_INTR_MASK: m_mask = acc.wdata[10:0];
        OFF_RX_TL:     m_rx_tl = acc.wdata[7:0];
        OFF_TX_TL:     m_tx_tl = acc.wdata[7:0];
        OFF_ENABLE:    m_en = acc.wdata[0];
        OFF_SDA_HOLD:  m_sda_hold = acc.wdata;
        OFF_DATA_NACK: m_nack = acc.wdata[0];
        OFF_DMA_CR:    m_dma_cr = acc.wdata[1:0];
        OFF_DMA_TDLR:  m_dma_tdlr = acc.wdata[7:0];
        OFF_DMA_RDLR:  m_dma_rdlr = acc.wdata[7:0];
        OFF_SDA_SETUP: m_sda_setup = acc.wdata[7:0];
        OFF_ACK_GC:    m_gc_ack = acc.wdata[0];
        default: ;
      endcase
    end else begin
      case (acc.offset)
        OFF_CON:       rep.rdata = 32'(m_ctl);
        OFF_TAR:       rep.rdata = 32'(m_tar);
        OFF_SAR:       rep.rdata = 32'(m_sar);
        OFF_DATA_CMD: begin
          // Pop the FIFO; an empty FIFO reads as all ones and flags underflow.
          if (m_rx_level == 0) begin
            m_raw = m_raw | IRQ_RX_UNDER;
            rep.rdata = 32'h0000_00FF;
          end else begin
            rep.rdata = 32'(m_rxq[m_rx_head]);
            m_rx_head = m_rx_head + 4'd1;
            m_rx_level = m_rx_level - 5'd1;
            if (m_rx_level == 0) begin
              m_raw = m_raw & ~IRQ_RX_FULL;
              m_rx_head = '0;
            end
          end
        end
        OFF_INTR_STAT:     rep.rdata = 32'(m_raw & m_mask[9:0]);
        OFF_INTR_MASK:     rep.rdata = 32'(m_mask);
        OFF_RAW_INTR:      rep.rdata = 32'(m_raw);
        OFF_RX_TL:         rep.rdata = 32'(m_rx_tl);
        OFF_TX_TL:         rep.rdata = 32'(m_tx_tl);
        OFF_CLR_INTR:      m_raw = '0;
        OFF_CLR_RX_UNDER:  m_raw = m_raw & ~IRQ_RX_UNDER;
        OFF_CLR_TX_ABRT:   m_raw = m_raw & ~IRQ_TX_ABRT;
        OFF_CLR_STOP_DET:  m_raw = m_raw & ~IRQ_STOP_DET;
        OFF_ENABLE:        rep.rdata = 32'(m_en);
        OFF_STATUS: begin
          if (m_en) rep.rdata = 32'h6 | ((m_rx_level != 0) ? 32'h8 : 32'h0);
        end
        OFF_RXFLR:         rep.rdata = 32'(m_rx_level);
        OFF_SDA_HOLD:      rep.rdata = m_sda_hold;
        OFF_DATA_NACK:     rep.rdata = 32'(m_nack);
        OFF_DMA_CR:        rep.rdata = 32'(m_dma_cr);
        OFF_DMA_TDLR:      rep.rdata = 32'(m_dma_tdlr);
        OFF_DMA_RDLR:      rep.rdata = 32'(m_dma_rdlr);
        OFF_SDA_SETUP:     rep.rdata = 32'(m_sda_setup);
        OFF_ACK_GC:        rep.rdata = 32'(m_gc_ack);
        OFF_ENABLE_STATUS: rep.rdata = 32'(m_en);
        OFF_COMP_PARAM:    rep.rdata = COMP_PARAM_VAL;
        OFF_COMP_VER:      rep.rdata = COMP_VER_VAL;
        OFF_COMP_TYPE:     rep.rdata = COMP_TYPE_VAL;
        default: ;
      endcase
    end
    rep.irq = |(m_raw & m_mask[9:0]);
    return rep;
  endfunction

  // Monitor: predicts each accepted item and checks each accepted reply.
  always @(posedge clk) begin : monitor
    reg_access_t acc;
    reg_reply_t  want;
    if (!rst_n) begin
      m_rom_on = 1'b0;
      m_ctl = 7'h63;
      m_tar = '0;
      m_sar = '0;
      m_mask = '0;
      m_raw = '0;
      m_rx_tl = '0;
      m_tx_tl = '0;
      m_en = 1'b0;
      m_sda_hold = '0;
      m_sda_setup = '0;
      m_gc_ack = 1'b0;
      m_dma_cr = '0;
      m_dma_tdlr = '0;
      m_dma_rdlr = '0;
      m_nack = 1'b0;
      m_rom_ptr = '0;
      m_rx_level = '0;
      m_rx_head = '0;
      in_fire = 1'b0;
    end else begin
      if (cfg_we) m_rom_on = cfg_wdata;
      in_fire = in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        acc.kind = acc_kind_e'(in_tuser);
        acc.offset = in_tdata[7:0];
        acc.wdata = in_tdata[39:8];
        expected_replies.push_back(predict_reply(acc));
        n_taken++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_replies.size() == 0) begin
          $error("reply with no item outstanding: tdata %h", out_tdata);
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          if (out_tdata[31:0] !== want.rdata) begin
            $error("read_value: expected %h, got %h", want.rdata, out_tdata[31:0]);
            fail_count++;
          end
          if (out_tdata[32] !== want.irq) begin
            $error("irq_level: expected %b, got %b", want.irq, out_tdata[32]);
            fail_count++;
          end
          if (out_tdata[39:33] !== 7'd0) begin
            $error("tdata padding: expected %h, got %h", 7'd0, out_tdata[39:33]);
            fail_count++;
          end
        end
      end
    end
  end

  // Driver: offers the next pending item once the current one is taken.
  always @(negedge clk) begin : driver
    reg_access_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (pending_accesses.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = pending_accesses.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= nxt.kind;
        in_tdata <= {nxt.wdata, nxt.offset};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus an occasional long hold-off.
  always @(negedge clk) begin : receiver
    if (hold_trig != hold_seen) begin
      hold_seen = hold_trig;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Watchdog on cycles in which no item moves on either side.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic queue_access(input acc_kind_e kind, input logic [7:0] offset,
                              input logic [31:0] wdata);
    reg_access_t acc;
    acc.kind = kind;
    acc.offset = offset;
    acc.wdata = wdata;
    pending_accesses.push_back(acc);
    n_queued++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (n_taken != n_queued || expected_replies.size() != 0);
  endtask

  // Changes the ROM-present flag once the block has gone idle.
  task automatic set_rom_present(input logic present);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_wdata <= present;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One access to a mapped register with random direction and data.
  task automatic queue_reg_op();
    logic [31:0] data;
    case ($urandom_range(3))
      0:       data = '1;
      1:       data = '0;
      default: data = $urandom;
    endcase
    queue_access(acc_kind_e'($urandom_range(1)), REG_MAP[$urandom_range(30)], data);
  endtask

  // ROM transfer: address the device (rarely another), often set the pointer, fetch bytes, pop them.
  task automatic queue_rom_transfer();
    int n_fetch;
    int n_pop;
    int k;
    if ($urandom_range(9) == 0)
      queue_access(ACC_WRITE, OFF_TAR, $urandom);
    else
      queue_access(ACC_WRITE, OFF_TAR, ($urandom & 32'hFFFF_FC00) | 32'(ROM_DEV_ADDR));
    if ($urandom_range(3) != 0)
      queue_access(ACC_WRITE, OFF_DATA_CMD,
                   ($urandom & 32'hFFFF_FE00) |
                   (($urandom_range(1) != 0) ? 32'($urandom_range(140)) : 32'($urandom_range(255))));
    n_fetch = ($urandom_range(3) == 0) ? $urandom_range(22, 14) : $urandom_range(6, 1);
    for (k = 0; k < n_fetch; k++) begin
      queue_access(ACC_WRITE, OFF_DATA_CMD, $urandom | DATA_CMD_READ);
      if ($urandom_range(7) == 0) queue_reg_op();
    end
    n_pop = $urandom_range(n_fetch + 2);
    for (k = 0; k < n_pop; k++) begin
      queue_access(ACC_READ, OFF_DATA_CMD, $urandom);
      if ($urandom_range(9) == 0) queue_access(ACC_READ, OFF_STATUS, $urandom);
    end
  endtask

  // Random traffic: mostly ROM transfers, then register accesses and noise.
  task automatic queue_traffic(input int count);
    int start;
    int pick;
    start = n_queued;
    while (n_queued - start < count) begin
      pick = $urandom_range(99);
      if (pick < 45) queue_rom_transfer();
      else if (pick < 80) queue_reg_op();
      else queue_access(acc_kind_e'($urandom_range(1)), 8'($urandom_range(255)), $urandom);
    end
  endtask

  // Sequence of phases.
  initial begin : stimulus
    int base;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_rom_present(1'b1);
    @(posedge clk);
    // Directed accesses: identification registers, FIFO underflow and emptying,
    // pointer wrap, ignored writes, unknown offsets and a missing device.
    queue_access(ACC_READ, OFF_CON, '0);
    queue_access(ACC_READ, OFF_COMP_PARAM, '1);
    queue_access(ACC_READ, OFF_COMP_VER, '0);
    queue_access(ACC_READ, OFF_COMP_TYPE, '0);
    queue_access(ACC_WRITE, OFF_INTR_MASK, '1);
    queue_access(ACC_READ, OFF_DATA_CMD, '0);
    queue_access(ACC_WRITE, OFF_TAR, 32'(ROM_DEV_ADDR));
    queue_access(ACC_WRITE, OFF_DATA_CMD, 32'hFFFF_FE86);
    queue_access(ACC_WRITE, OFF_DATA_CMD, DATA_CMD_READ);
    queue_access(ACC_WRITE, OFF_DATA_CMD, DATA_CMD_READ);
    queue_access(ACC_WRITE, OFF_ENABLE, '1);
    queue_access(ACC_READ, OFF_STATUS, '0);
    queue_access(ACC_READ, OFF_RXFLR, '0);
    queue_access(ACC_WRITE, OFF_DATA_CMD, 32'h0000_00FF);
    queue_access(ACC_WRITE, OFF_DATA_CMD, '1);
    queue_access(ACC_WRITE, OFF_DATA_CMD, DATA_CMD_READ);
    repeat (5) queue_access(ACC_READ, OFF_DATA_CMD, '0);
    queue_access(ACC_WRITE, OFF_RAW_INTR, '1);
    queue_access(ACC_WRITE, OFF_SS_HCNT, '1);
    queue_access(ACC_WRITE, 8'h31, '1);
    queue_access(ACC_READ, 8'h31, '0);
    queue_access(ACC_READ, OFF_CLR_INTR, '0);
    queue_access(ACC_WRITE, OFF_TAR, '1);
    queue_access(ACC_WRITE, OFF_DATA_CMD, DATA_CMD_READ);
    queue_access(ACC_READ, OFF_RAW_INTR, '0);
    wait_drained();

    // ROM present, random idling, one long receiver hold-off.
    @(posedge clk);
    base = n_taken;
    queue_traffic(350);
    while (n_taken < base + 120) @(negedge clk);
    @(posedge clk);
    hold_trig++;

    // ROM absent, no idling on either side.
    set_rom_present(1'b0);
    @(posedge clk);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    queue_traffic(250);

    // ROM present again, random idling, another hold-off.
    set_rom_present(1'b1);
    @(posedge clk);
    src_idle_pct = 30;
    snk_idle_pct = 30;
    base = n_taken;
    queue_traffic(450);
    while (n_taken < base + 300) @(negedge clk);
    @(posedge clk);
    hold_trig++;

    wait_drained();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
